/* design/afrb_pkg.sv */
`timescale 1ns / 1ps
package afrb_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned TC_W     = 49;
  localparam int unsigned RATE_W   = 25;
  localparam int unsigned CARD_W   = 20;
  localparam int unsigned DVS_W    = 28;
  localparam int unsigned SCALE_W  = 17;
  localparam int unsigned MAX_FRAG = 64;
  localparam int unsigned CFG_W    = 25;

  localparam logic [SCALE_W-1:0] TIME_SCALE = SCALE_W'(100000);

  typedef logic [2:0] func_t;
  typedef logic [1:0] status_t;
  typedef logic [2:0] cfg_addr_t;
  typedef logic signed [15:0] sample_t;
  typedef logic signed [TC_W-1:0] tc_t;

  localparam func_t FN_WRITE = 3'd0;
  localparam func_t FN_READ  = 3'd1;
  localparam func_t FN_CHUNK = 3'd2;
  localparam func_t FN_QUERY = 3'd3;
  localparam func_t FN_RESET = 3'd4;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DROP = 2'd1;
  localparam status_t ST_SHORT = 2'd2;

  localparam cfg_addr_t REG_WIDTH = 3'd0;
  localparam cfg_addr_t REG_CHANS = 3'd1;
  localparam cfg_addr_t REG_MUTE  = 3'd2;
  localparam cfg_addr_t REG_FRAG  = 3'd3;
  localparam cfg_addr_t REG_RATE  = 3'd4;

  localparam logic [1:0] MUTE_CH1_TO_CH0 = 2'd1;
  localparam logic [1:0] MUTE_CH0_TO_CH1 = 2'd2;

endpackage

/* design/audio_frame_ring_buffer_unit.sv */
`timescale 1ns / 1ps
// Byte ring buffer for interleaved PCM frames held in one 64 KiB single-port-write,
// registered-read memory; one byte always stays free. The store needs no clearing
// pass after reset. One item is worked at a time. A frame write takes one cycle per
// byte. A read issues one byte per cycle into the memory, then waits for the last
// byte to land and delivers the frame through the output handshake, repeating per
// frame up to a fragment. Chunk end and time queries run a bit-serial divider over
// the 49 quotient bits. Other items go straight to the output handshake.
module audio_frame_ring_buffer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  afrb_pkg::cfg_addr_t           cfg_addr_i,
  input  logic [afrb_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  afrb_pkg::func_t               func_i,
  input  afrb_pkg::sample_t             sample_0_i,
  input  afrb_pkg::sample_t             sample_1_i,
  input  afrb_pkg::sample_t             sample_2_i,
  input  afrb_pkg::sample_t             sample_3_i,
  input  afrb_pkg::tc_t                 chunk_timecode_i,
  input  logic                          partial_ok_i,
  input  logic [afrb_pkg::CARD_W-1:0]   card_buffered_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output afrb_pkg::status_t             status_o,
  output afrb_pkg::sample_t             out_sample_0_o,
  output afrb_pkg::sample_t             out_sample_1_o,
  output afrb_pkg::sample_t             out_sample_2_o,
  output afrb_pkg::sample_t             out_sample_3_o,
  output logic                          last_o,
  output logic [afrb_pkg::ADDR_W-1:0]   fill_bytes_o,
  output afrb_pkg::tc_t                 audio_time_o
);
  import afrb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_RD_ISS, S_RD_WAIT, S_RD_FIN, S_MUL, S_DIV, S_TFIN, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic              width_q;
  logic [2:0]        chans_q;
  logic [1:0]        mute_q;
  logic [6:0]        frag_q;
  logic [RATE_W-1:0] rate_q;

  logic [ADDR_W-1:0] wptr_q, rptr_q;
  logic [TC_W-1:0]   btc_q;
  logic [31:0]       cfc_q;

  logic [7:0]        mem [2**ADDR_W];
  logic [7:0]        rdata_q;

  logic [15:0]       smp_q [4];
  logic [15:0]       rs_q [4];
  logic [2:0]        bidx_q;
  logic [2:0]        cap_idx_q;
  logic              cap_vld_q;
  logic [6:0]        k_q;
  logic              is_query_q;
  logic [TC_W-1:0]   tc_in_q;
  logic [CARD_W-1:0] card_q;

  logic [TC_W-1:0]   dvd_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [5:0]        dcnt_q;

  status_t           status_q;
  logic [15:0]       os_q [4];
  logic              last_q;
  logic              rd_mode_q;
  logic [TC_W-1:0]   atime_q;

  // effective configuration
  logic [2:0]        nch;
  logic [3:0]        fb;
  logic [6:0]        frag;
  logic [RATE_W-1:0] rate;
  logic [ADDR_W-1:0] fill;
  logic [ADDR_W-1:0] need;
  logic [9:0]        frag_bytes;

  always_comb begin
    if (chans_q == 3'd0) nch = 3'd1;
    else if (chans_q > 3'd4) nch = 3'd4;
    else nch = chans_q;
    fb = width_q ? {nch, 1'b0} : {1'b0, nch};
    if (frag_q == 7'd0) frag = 7'd1;
    else if (frag_q > 7'(MAX_FRAG)) frag = 7'(MAX_FRAG);
    else frag = frag_q;
    rate = (rate_q == '0) ? RATE_W'(1) : rate_q;
    fill = wptr_q - rptr_q;
    frag_bytes = 10'(frag) * 10'(fb);
    need = partial_ok_i ? ADDR_W'(fb) : ADDR_W'(frag_bytes);
  end

  // write byte select: byte j of the frame
  logic [1:0] wch, cch;
  logic       whi, chi;
  logic [7:0] wbyte;
  logic       mem_we, mem_re;

  always_comb begin
    wch   = width_q ? bidx_q[2:1] : bidx_q[1:0];
    whi   = width_q & bidx_q[0];
    wbyte = whi ? smp_q[wch][15:8] : smp_q[wch][7:0];
    cch   = width_q ? cap_idx_q[2:1] : cap_idx_q[1:0];
    chi   = width_q & cap_idx_q[0];
    mem_we = (state_q == S_WR);
    mem_re = (state_q == S_RD_ISS);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wptr_q] <= wbyte;
    if (mem_re) rdata_q <= mem[rptr_q];
  end

  // divider step
  logic [DVS_W:0]  trial;
  logic            qbit;
  logic [TC_W-1:0] tc_base;
  logic [20:0]     total;

  always_comb begin
    trial   = {rem_q, dvd_q[TC_W-1]};
    qbit    = (trial >= {1'b0, dvs_q});
    tc_base = tc_in_q[TC_W-1] ? btc_q : tc_in_q;
    total   = 21'(fill) + 21'(card_q);
  end

  logic [15:0] mute0, mute1;
  always_comb begin
    mute0 = (nch > 3'd1 && mute_q == MUTE_CH1_TO_CH0) ? rs_q[1] : rs_q[0];
    mute1 = (nch > 3'd1 && mute_q == MUTE_CH0_TO_CH1) ? rs_q[0] : rs_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      width_q   <= 1'b1;
      chans_q   <= 3'd2;
      mute_q    <= 2'd0;
      frag_q    <= 7'd64;
      rate_q    <= RATE_W'(4410000);
      wptr_q    <= '0;
      rptr_q    <= '0;
      btc_q     <= '0;
      cfc_q     <= '0;
      cap_vld_q <= 1'b0;
      rd_mode_q <= 1'b0;
      last_q    <= 1'b0;
      status_q  <= ST_OK;
      atime_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_WIDTH: width_q <= cfg_wdata_i[0];
          REG_CHANS: chans_q <= cfg_wdata_i[2:0];
          REG_MUTE:  mute_q  <= cfg_wdata_i[1:0];
          REG_FRAG:  frag_q  <= cfg_wdata_i[6:0];
          REG_RATE:  rate_q  <= cfg_wdata_i[RATE_W-1:0];
          default: ;
        endcase
      end

      // byte from the memory lands in the cycle after its issue
      if (cap_vld_q) begin
        if (chi) begin
          rs_q[cch][15:8] <= rdata_q;
        end else begin
          rs_q[cch][7:0]  <= rdata_q;
          rs_q[cch][15:8] <= width_q ? rs_q[cch][15:8] : {8{rdata_q[7]}};
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            smp_q[0]  <= sample_0_i;
            smp_q[1]  <= sample_1_i;
            smp_q[2]  <= sample_2_i;
            smp_q[3]  <= sample_3_i;
            tc_in_q   <= chunk_timecode_i;
            card_q    <= card_buffered_i;
            bidx_q    <= '0;
            k_q       <= '0;
            rd_mode_q <= 1'b0;
            last_q    <= 1'b1;
            status_q  <= ST_OK;
            atime_q   <= '0;
            for (int c = 0; c < 4; c++) begin
              os_q[c] <= '0;
              rs_q[c] <= '0;
            end
            unique case (func_i)
              FN_WRITE: begin
                if (ADDR_W'(fb) > ~fill) begin
                  status_q <= ST_DROP;
                  state_q  <= S_OUT;
                end else begin
                  state_q <= S_WR;
                end
              end
              FN_READ: begin
                if (fill < need) begin
                  status_q <= ST_SHORT;
                  state_q  <= S_OUT;
                end else begin
                  rd_mode_q <= 1'b1;
                  state_q   <= S_RD_ISS;
                end
              end
              FN_CHUNK: begin
                is_query_q <= 1'b0;
                state_q    <= S_MUL;
              end
              FN_QUERY: begin
                is_query_q <= 1'b1;
                state_q    <= (btc_q == '0) ? S_OUT : S_MUL;
              end
              FN_RESET: begin
                wptr_q  <= '0;
                rptr_q  <= '0;
                btc_q   <= '0;
                cfc_q   <= '0;
                state_q <= S_OUT;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_WR: begin
          wptr_q <= wptr_q + ADDR_W'(1);
          bidx_q <= bidx_q + 3'd1;
          if ({1'b0, bidx_q} == fb - 4'd1) begin
            cfc_q   <= cfc_q + 32'd1;
            state_q <= S_OUT;
          end
        end
        S_RD_ISS: begin
          rptr_q    <= rptr_q + ADDR_W'(1);
          cap_vld_q <= 1'b1;
          cap_idx_q <= bidx_q;
          bidx_q    <= bidx_q + 3'd1;
          if ({1'b0, bidx_q} == fb - 4'd1) state_q <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          cap_vld_q <= 1'b0;
          state_q   <= S_RD_FIN;
        end
        S_RD_FIN: begin
          os_q[0] <= mute0;
          os_q[1] <= mute1;
          os_q[2] <= rs_q[2];
          os_q[3] <= rs_q[3];
          last_q  <= (k_q + 7'd1 == frag) || (fill < ADDR_W'(fb));
          state_q <= S_OUT;
        end
        S_MUL: begin
          if (is_query_q) begin
            dvd_q <= TC_W'(38'(total) * 38'(TIME_SCALE));
            dvs_q <= DVS_W'(fb) * DVS_W'(rate);
          end else begin
            dvd_q <= TC_W'(cfc_q) * TC_W'(TIME_SCALE);
            dvs_q <= DVS_W'(rate);
          end
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
          dvd_q  <= {dvd_q[TC_W-2:0], qbit};
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'(TC_W - 1)) state_q <= S_TFIN;
        end
        S_TFIN: begin
          if (is_query_q) begin
            atime_q <= btc_q - dvd_q;
          end else begin
            btc_q <= tc_base + dvd_q;
            cfc_q <= '0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            if (rd_mode_q && !last_q) begin
              k_q     <= k_q + 7'd1;
              bidx_q  <= '0;
              for (int c = 0; c < 4; c++) rs_q[c] <= '0;
              state_q <= S_RD_ISS;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign status_o       = status_q;
  assign out_sample_0_o = os_q[0];
  assign out_sample_1_o = os_q[1];
  assign out_sample_2_o = os_q[2];
  assign out_sample_3_o = os_q[3];
  assign last_o         = last_q;
  assign fill_bytes_o   = fill;
  assign audio_time_o   = atime_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import afrb_pkg::*;

  typedef struct packed {
    func_t             func;
    sample_t           s0;
    sample_t           s1;
    sample_t           s2;
    sample_t           s3;
    tc_t               tc;
    logic              partial;
    logic [CARD_W-1:0] card;
  } item_t;

  typedef struct packed {
    status_t           status;
    sample_t           o0;
    sample_t           o1;
    sample_t           o2;
    sample_t           o3;
    logic              last;
    logic [ADDR_W-1:0] fill;
    tc_t               atime;
  } frame_res_t;

  // directed rows: item, whether a typed-in answer applies, and that answer
  typedef struct packed {
    item_t      it;
    logic       has_exp;
    frame_res_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_addr_t cfg_addr_i = REG_WIDTH;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  func_t func_i = FN_WRITE;
  sample_t sample_0_i = '0, sample_1_i = '0, sample_2_i = '0, sample_3_i = '0;
  tc_t chunk_timecode_i = '0;
  logic partial_ok_i = 1'b0;
  logic [CARD_W-1:0] card_buffered_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  status_t status_o;
  sample_t out_sample_0_o, out_sample_1_o, out_sample_2_o, out_sample_3_o;
  logic last_o;
  logic [ADDR_W-1:0] fill_bytes_o;
  tc_t audio_time_o;

  audio_frame_ring_buffer_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the ring
  logic [7:0]        ring [0:65535];
  logic [ADDR_W-1:0] wr_ptr, rd_ptr;
  logic [TC_W-1:0]   buf_tc;
  logic [31:0]       chunk_frames;
  logic              width16;
  logic [2:0]        chan_reg;
  logic [1:0]        mute_reg;
  logic [6:0]        frag_reg;
  logic [RATE_W-1:0] rate_reg;

  frame_res_t expected_frames[$];
  int  errors = 0;
  bit  idle_free = 0;
  int  stall_pct = 17;

  function automatic int unsigned fill_level();
    return 32'(ADDR_W'(wr_ptr - rd_ptr));
  endfunction

  function automatic int unsigned n_chans();
    if (chan_reg == 0) return 1;
    if (chan_reg > 4) return 4;
    return chan_reg;
  endfunction

  function automatic int unsigned frame_bytes();
    return n_chans() * (width16 ? 2 : 1);
  endfunction

  function automatic logic [63:0] eff_rate();
    return (rate_reg == 0) ? 64'd1 : 64'(rate_reg);
  endfunction

  function automatic frame_res_t plain_res(status_t st, tc_t at);
    frame_res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    r.fill = ADDR_W'(fill_level());
    r.atime = at;
    return r;
  endfunction

  task automatic predict_ring(input item_t it);
    int unsigned nch, fb, held, frag, n;
    logic [15:0] s [4];
    logic [15:0] v;
    logic [7:0] lo, hi;
    logic [63:0] adv, total, delay;
    logic [TC_W-1:0] base, t;
    frame_res_t r;
    nch = n_chans();
    fb = frame_bytes();
    case (it.func)
      FN_WRITE: begin
        if (fb > 65535 - fill_level()) begin
          expected_frames.push_back(plain_res(ST_DROP, '0));
        end else begin
          s[0] = it.s0; s[1] = it.s1; s[2] = it.s2; s[3] = it.s3;
          for (int c = 0; c < nch; c++) begin
            ring[wr_ptr] = s[c][7:0];
            wr_ptr++;
            if (width16) begin
              ring[wr_ptr] = s[c][15:8];
              wr_ptr++;
            end
          end
          chunk_frames++;
          expected_frames.push_back(plain_res(ST_OK, '0));
        end
      end
      FN_READ: begin
        frag = (frag_reg == 0) ? 1 : (frag_reg > MAX_FRAG ? MAX_FRAG : frag_reg);
        held = fill_level() / fb;
        if (held >= frag) n = frag;
        else if (it.partial && held > 0) n = held;
        else n = 0;
        if (n == 0) expected_frames.push_back(plain_res(ST_SHORT, '0));
        for (int k = 0; k < n; k++) begin
          s = '{default: 16'h0};
          for (int c = 0; c < nch; c++) begin
            lo = ring[rd_ptr];
            rd_ptr++;
            if (width16) begin
              hi = ring[rd_ptr];
              rd_ptr++;
              v = {hi, lo};
            end else begin
              v = {{8{lo[7]}}, lo};
            end
            s[c] = v;
          end
          if (nch > 1) begin
            if (mute_reg == MUTE_CH1_TO_CH0) s[0] = s[1];
            else if (mute_reg == MUTE_CH0_TO_CH1) s[1] = s[0];
          end
          r = plain_res(ST_OK, '0);
          r.o0 = s[0]; r.o1 = s[1]; r.o2 = s[2]; r.o3 = s[3];
          r.last = (k + 1 == n);
          expected_frames.push_back(r);
        end
      end
      FN_CHUNK: begin
        base = it.tc[TC_W-1] ? buf_tc : it.tc;
        adv = (64'(chunk_frames) * 64'd100000) / eff_rate();
        buf_tc = base + TC_W'(adv);
        chunk_frames = 0;
        expected_frames.push_back(plain_res(ST_OK, '0));
      end
      FN_QUERY: begin
        t = '0;
        if (buf_tc != 0) begin
          total = 64'(fill_level()) + 64'(it.card);
          delay = (total * 64'd100000) / (64'(fb) * eff_rate());
          t = buf_tc - TC_W'(delay);
        end
        expected_frames.push_back(plain_res(ST_OK, t));
      end
      FN_RESET: begin
        wr_ptr = '0; rd_ptr = '0; buf_tc = '0; chunk_frames = 0;
        expected_frames.push_back(plain_res(ST_OK, '0));
      end
      default: expected_frames.push_back(plain_res(ST_OK, '0));
    endcase
  endtask

  task automatic write_reg(input cfg_addr_t a, input logic [CFG_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (a)
      REG_WIDTH: width16 = d[0];
      REG_CHANS: chan_reg = d[2:0];
      REG_MUTE:  mute_reg = d[1:0];
      REG_FRAG:  frag_reg = d[6:0];
      REG_RATE:  rate_reg = d[RATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // valid stays high from one accepted item to the next unless the sender idles
  task automatic send_item(input item_t it);
    if (!idle_free) begin
      while ($urandom_range(99) < stall_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    func_i <= it.func;
    sample_0_i <= it.s0; sample_1_i <= it.s1;
    sample_2_i <= it.s2; sample_3_i <= it.s3;
    chunk_timecode_i <= it.tc;
    partial_ok_i <= it.partial;
    card_buffered_i <= it.card;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_ring(it);
  endtask

  function automatic item_t rand_item(int unsigned op);
    item_t it;
    it.func = func_t'(op);
    it.s0 = sample_t'($urandom); it.s1 = sample_t'($urandom);
    it.s2 = sample_t'($urandom); it.s3 = sample_t'($urandom);
    it.tc = ($urandom_range(3) == 0) ? '1 : tc_t'({$urandom, $urandom}) >> 1;
    if ($urandom_range(4) == 0) it.tc = {1'b0, {(TC_W-1){1'b1}}};
    it.partial = 1'($urandom_range(1));
    it.card = CARD_W'($urandom);
    return it;
  endfunction

  function automatic item_t mk(func_t f, int a, int b, int c, int d,
                               longint tc, int p, int cb);
    item_t it;
    it.func = f;
    it.s0 = sample_t'(a); it.s1 = sample_t'(b);
    it.s2 = sample_t'(c); it.s3 = sample_t'(d);
    it.tc = tc_t'(tc); it.partial = 1'(p); it.card = CARD_W'(cb);
    return it;
  endfunction

  // output side: stalls and scoreboard compare
  always @(posedge clk_i) begin
    frame_res_t got, want;
    if (rst_ni) begin
      out_ready_i <= idle_free ? 1'b1 : ($urandom_range(99) >= stall_pct);
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, out_sample_0_o, out_sample_1_o, out_sample_2_o,
                out_sample_3_o, last_o, fill_bytes_o, audio_time_o};
        if (expected_frames.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, actual %h", $time, got);
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: status exp %0d act %0d", $time, want.status, got.status);
            $display("%0t: samples exp %h %h %h %h act %h %h %h %h", $time,
                     want.o0, want.o1, want.o2, want.o3, got.o0, got.o1, got.o2, got.o3);
            $display("%0t: last exp %0d act %0d, fill exp %0d act %0d", $time,
                     want.last, got.last, want.fill, got.fill);
            $display("%0t: audio_time exp %0d act %0d", $time, want.atime, got.atime);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // config phases: width, chans, mute, frag, rate
  typedef logic [CFG_W-1:0] cfg_set_t [5];

  initial begin
    row_t rows[$];
    row_t rw;
    frame_res_t e;
    cfg_set_t phases[$];
    cfg_set_t ph;
    int unsigned pick;
    for (int i = 0; i < 65536; i++) ring[i] = '0;
    wr_ptr = '0; rd_ptr = '0; buf_tc = '0; chunk_frames = 0;
    width16 = 1'b1; chan_reg = 3'd2; mute_reg = '0; frag_reg = 7'd64;
    rate_reg = RATE_W'(4410000);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset configuration
    e = '0; e.last = 1'b1;
    rw.has_exp = 1'b1;
    rw.it = mk(FN_READ, 0, 0, 0, 0, 0, 1, 0); e.status = ST_SHORT; rw.exp = e;
    rows.push_back(rw);
    rw.it = mk(FN_QUERY, 0, 0, 0, 0, 0, 0, '1); e.status = ST_OK; rw.exp = e;
    rows.push_back(rw);
    rw.it = mk(FN_WRITE, 16'sh7fff, -16'sh8000, 0, 0, 0, 0, 0); e.fill = 16'd4; rw.exp = e;
    rows.push_back(rw);
    rw.it = mk(FN_WRITE, -16'sd1, 16'sd0, 0, 0, 0, 0, 0); e.fill = 16'd8; rw.exp = e;
    rows.push_back(rw);
    rw.it = mk(FN_READ, 0, 0, 0, 0, 0, 0, 0); e.status = ST_SHORT; rw.exp = e;
    rows.push_back(rw);
    rw.has_exp = 1'b0;
    rw.it = mk(FN_CHUNK, 0, 0, 0, 0, 1000, 0, 0); rows.push_back(rw);
    rw.it = mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 176400); rows.push_back(rw);
    rw.it = mk(FN_CHUNK, 0, 0, 0, 0, '1, 0, 0); rows.push_back(rw);
    rw.it = mk(FN_READ, 0, 0, 0, 0, 0, 1, 0); rows.push_back(rw);
    rw.it = mk(FN_CHUNK, 0, 0, 0, 0, {1'b0, {(TC_W-1){1'b1}}}, 0, 0); rows.push_back(rw);
    rw.it = mk(FN_QUERY, 0, 0, 0, 0, 0, 0, '1); rows.push_back(rw);
    rw.it = mk(func_t'(3'd5), 1, 2, 3, 4, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(func_t'(3'd7), 1, 2, 3, 4, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(FN_WRITE, 16'sh1234, 16'sh5678, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.has_exp = 1'b1; e = '0; e.last = 1'b1;
    rw.it = mk(FN_RESET, 0, 0, 0, 0, 0, 0, 0); rw.exp = e; rows.push_back(rw);
    rw.it = mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 5); rw.exp = e; rows.push_back(rw);
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].has_exp) expected_frames[expected_frames.size()-1] = rows[i].exp;
    end
    drain_results();

    // settings including extremes and out of range values
    phases.push_back('{0, 1, 0, 1, 100});
    phases.push_back('{1, 4, 1, 64, 19200000});
    phases.push_back('{0, 2, 2, 3, 4410000});
    phases.push_back('{1, 0, 3, 0, 0});
    phases.push_back('{0, 7, 1, 127, 33554431});
    phases.push_back('{1, 2, 1, 5, 4800000});
    phases.push_back('{1, 3, 2, 100, 800000});
    phases.push_back('{0, 2, 2, 16, 1234567});

    foreach (phases[p]) begin
      ph = phases[p];
      for (int r = 0; r < 5; r++) write_reg(cfg_addr_t'(r), ph[r]);
      cfg_we_i <= 1'b0;
      idle_free = (p == 2);
      for (int i = 0; i < 27; i++) begin
        pick = $urandom_range(99);
        if (pick < 55) send_item(rand_item(FN_WRITE));
        else if (pick < 75) send_item(rand_item(FN_READ));
        else if (pick < 85) send_item(rand_item(FN_CHUNK));
        else if (pick < 95) send_item(rand_item(FN_QUERY));
        else if (pick < 97) send_item(rand_item(FN_RESET));
        else send_item(rand_item($urandom_range(7, 5)));
        if (i == 15 && p == 4) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (expected_frames.size() != 0) @(posedge clk_i);
        end
      end
      drain_results();
    end
    idle_free = 0;

    drain_results();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
